// ===== sv/swrc_pkg.sv =====
// Package for the sliding window range check: field widths, register
// codes and the control structs passed between sequencer, chain and cells.
// No dependencies.
package swrc_pkg;

    localparam int SAMPLE_W = 20;
    localparam int POS_W    = 32;
    localparam int WLEN_W   = 11;
    localparam int THR_W    = 20;

    localparam logic [POS_W-1:0] POS_TOP = '1;

    localparam logic REG_WINDOW_LEN = 1'b0;
    localparam logic REG_THRESHOLD  = 1'b1;

    typedef struct packed {
        logic clear;
        logic expire;
        logic step;
    } seq_ctrl_t;

    typedef struct packed {
        logic clear;
        logic shift;
        logic step;
        logic exp;
        logic full;
    } cell_ctrl_t;

endpackage

// ===== sv/swrc_cell.sv =====
// One candidate cell: value, position and valid bit of a monotonic list.
// Uses swrc_pkg; instantiated by swrc_chain.
module swrc_cell #(
    parameter int VAL_W    = 20,
    parameter bit KEEP_MAX = 1'b1,
    parameter bit IS_TAIL  = 1'b0
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  swrc_pkg::cell_ctrl_t        ctrl,
    input  logic [VAL_W-1:0]            new_value,
    input  logic [swrc_pkg::POS_W-1:0]  new_pos,
    input  logic                        right_valid,
    input  logic [VAL_W-1:0]            right_value,
    input  logic [swrc_pkg::POS_W-1:0]  right_pos,
    input  logic                        left_pv,
    output logic                        valid,
    output logic [VAL_W-1:0]            value,
    output logic [swrc_pkg::POS_W-1:0]  pos,
    output logic                        pv
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [VAL_W-1:0]           value_reg;
    logic [VAL_W-1:0]           value_next;
    logic [swrc_pkg::POS_W-1:0] pos_reg;
    logic [swrc_pkg::POS_W-1:0] pos_next;
    logic                       sv_valid;
    logic [VAL_W-1:0]           sv_value;
    logic [swrc_pkg::POS_W-1:0] sv_pos;
    logic                       dom;
    logic                       target;

    always_comb begin
        sv_valid = ctrl.exp ? right_valid : valid_reg;
        sv_value = ctrl.exp ? right_value : value_reg;
        sv_pos   = ctrl.exp ? right_pos   : pos_reg;
        if (KEEP_MAX) begin
            dom = sv_valid && (sv_value <= new_value);
        end else begin
            dom = sv_valid && (sv_value >= new_value);
        end
        pv     = sv_valid && !dom;
        target = ctrl.full ? IS_TAIL : (!pv && left_pv);
    end

    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        pos_next   = pos_reg;
        if (ctrl.clear) begin
            valid_next = 1'b0;
        end else if (ctrl.shift) begin
            valid_next = right_valid;
            value_next = right_value;
            pos_next   = right_pos;
        end else if (ctrl.step) begin
            if (target) begin
                valid_next = 1'b1;
                value_next = new_value;
                pos_next   = new_pos;
            end else if (ctrl.full) begin
                valid_next = right_valid;
                value_next = right_value;
                pos_next   = right_pos;
            end else begin
                valid_next = pv;
                value_next = sv_value;
                pos_next   = sv_pos;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        value_reg <= value_next;
        pos_reg   <= pos_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;
    assign pos   = pos_reg;

endmodule

// ===== sv/swrc_chain.sv =====
// Row of candidate cells for one monotonic list (maximum or minimum),
// with front expiry check and full detection. Uses swrc_pkg and swrc_cell.
module swrc_chain #(
    parameter int DEPTH    = 1024,
    parameter int VAL_W    = 20,
    parameter bit KEEP_MAX = 1'b1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  swrc_pkg::seq_ctrl_t         ctrl,
    input  logic [VAL_W-1:0]            new_value,
    input  logic [swrc_pkg::POS_W-1:0]  new_pos,
    input  logic [swrc_pkg::POS_W-1:0]  lim,
    input  logic                        lim_ok,
    output logic                        exp_two,
    output logic [VAL_W-1:0]            front_value
);

    logic                       valid_w [DEPTH];
    logic [VAL_W-1:0]           value_w [DEPTH];
    logic [swrc_pkg::POS_W-1:0] pos_w   [DEPTH];
    logic                       pv_w    [DEPTH];
    logic                       exp0;
    logic                       exp1;
    swrc_pkg::cell_ctrl_t       cctrl;

    assign exp0 = valid_w[0] && lim_ok && (pos_w[0] <= lim);

    generate
        if (DEPTH > 1) begin : g_second
            assign exp1 = valid_w[1] && lim_ok && (pos_w[1] <= lim);
        end else begin : g_single
            assign exp1 = 1'b0;
        end
    endgenerate

    assign exp_two = exp0 && exp1;

    always_comb begin
        cctrl.clear = ctrl.clear;
        cctrl.shift = ctrl.expire && exp_two;
        cctrl.step  = ctrl.step;
        cctrl.exp   = ctrl.step && exp0;
        cctrl.full  = ctrl.step && !exp0 && pv_w[DEPTH-1];
    end

    generate
        for (genvar i = 0; i < DEPTH; i++) begin : g_cell
            logic                       r_valid;
            logic [VAL_W-1:0]           r_value;
            logic [swrc_pkg::POS_W-1:0] r_pos;
            logic                       l_pv;

            if (i < DEPTH - 1) begin : g_right
                assign r_valid = valid_w[i+1];
                assign r_value = value_w[i+1];
                assign r_pos   = pos_w[i+1];
            end else begin : g_end
                assign r_valid = 1'b0;
                assign r_value = '0;
                assign r_pos   = '0;
            end

            if (i > 0) begin : g_left
                assign l_pv = pv_w[i-1];
            end else begin : g_head
                assign l_pv = 1'b1;
            end

            swrc_cell #(
                .VAL_W    (VAL_W),
                .KEEP_MAX (KEEP_MAX),
                .IS_TAIL  (i == DEPTH - 1)
            ) u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctrl        (cctrl),
                .new_value   (new_value),
                .new_pos     (new_pos),
                .right_valid (r_valid),
                .right_value (r_value),
                .right_pos   (r_pos),
                .left_pv     (l_pv),
                .valid       (valid_w[i]),
                .value       (value_w[i]),
                .pos         (pos_w[i]),
                .pv          (pv_w[i])
            );
        end
    endgenerate

    assign front_value = value_w[0];

endmodule

// ===== sv/sliding_window_range_check.sv =====
// Sliding window range check: for every full window of window_len samples,
// emit the window start position, maximum and minimum when max - min <= threshold.
// Uses swrc_pkg and swrc_chain (maximum and minimum candidate rows).
//
// Each sample passes through the transfer, an update state in which the
// candidate cells of both rows shift, drop dominated entries and append the
// sample in parallel, and a result state that compares the front cells.
// After window_len is shortened, the update state repeats while two front cells
// of a row have expired; the rows drop at most one expired front cell per cycle.
// The output register lets the next sample enter while a result waits; the
// result cycle of that next sample holds until the waiting result is taken.
// The first_sample flag (s_tuser) clears both rows and restarts positions at 1.
module sliding_window_range_check #(
    parameter int MAX_WINDOW  = 1024,
    parameter int SAMPLE_BITS = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [19:0] sample, [23:20] zero
    input  logic        s_tuser,   // [0] first_sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [31:0] window_start, [51:32] window_max,
                                   // [71:52] window_min
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int VAL_W = (SAMPLE_BITS < swrc_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                               : swrc_pkg::SAMPLE_W;
    localparam int LEN_W = $clog2(MAX_WINDOW + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_RESULT
    } state_t;

    state_t                         state_reg, state_next;
    logic [swrc_pkg::WLEN_W-1:0]    window_len_reg;
    logic [swrc_pkg::THR_W-1:0]     threshold_reg;
    logic [swrc_pkg::POS_W-1:0]     count_reg, count_next;
    logic [swrc_pkg::POS_W-1:0]     lim_reg, lim_next;
    logic                           lim_ok_reg, lim_ok_next;
    logic [VAL_W-1:0]               sample_reg, sample_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [71:0]                    m_tdata_reg, m_tdata_next;

    logic [31:0]                    wl_ext;
    logic [LEN_W-1:0]               len_eff;
    logic                           s_xfer;
    logic                           cfg_wr;
    logic                           max_exp_two;
    logic                           min_exp_two;
    logic [VAL_W-1:0]               max_front;
    logic [VAL_W-1:0]               min_front;
    logic [VAL_W-1:0]               diff;
    logic                           hit;
    swrc_pkg::seq_ctrl_t            sctrl;

    assign pready   = 1'b1;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        unique case (paddr[2])
            swrc_pkg::REG_WINDOW_LEN: prdata = 32'(window_len_reg);
            swrc_pkg::REG_THRESHOLD:  prdata = 32'(threshold_reg);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_len_reg <= swrc_pkg::WLEN_W'(1);
            threshold_reg  <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                swrc_pkg::REG_WINDOW_LEN: window_len_reg <= pwdata[swrc_pkg::WLEN_W-1:0];
                swrc_pkg::REG_THRESHOLD:  threshold_reg  <= pwdata[swrc_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        wl_ext = 32'(window_len_reg);
        if (wl_ext == 32'd0) begin
            len_eff = LEN_W'(1);
        end else if (wl_ext > 32'(MAX_WINDOW)) begin
            len_eff = LEN_W'(MAX_WINDOW);
        end else begin
            len_eff = LEN_W'(wl_ext);
        end
    end

    swrc_chain #(
        .DEPTH    (MAX_WINDOW),
        .VAL_W    (VAL_W),
        .KEEP_MAX (1'b1)
    ) u_max_chain (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (sctrl),
        .new_value   (sample_reg),
        .new_pos     (count_reg),
        .lim         (lim_reg),
        .lim_ok      (lim_ok_reg),
        .exp_two     (max_exp_two),
        .front_value (max_front)
    );

    swrc_chain #(
        .DEPTH    (MAX_WINDOW),
        .VAL_W    (VAL_W),
        .KEEP_MAX (1'b0)
    ) u_min_chain (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (sctrl),
        .new_value   (sample_reg),
        .new_pos     (count_reg),
        .lim         (lim_reg),
        .lim_ok      (lim_ok_reg),
        .exp_two     (min_exp_two),
        .front_value (min_front)
    );

    assign diff = max_front - min_front;
    assign hit  = lim_ok_reg && (32'(diff) <= 32'(threshold_reg));

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        lim_next      = lim_reg;
        lim_ok_next   = lim_ok_reg;
        sample_next   = sample_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        sctrl         = '0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    sample_next = s_tdata[VAL_W-1:0];
                    sctrl.clear = s_tuser;
                    if (s_tuser) begin
                        count_next = swrc_pkg::POS_W'(1);
                    end else if (count_reg == swrc_pkg::POS_TOP) begin
                        count_next = swrc_pkg::POS_TOP;
                    end else begin
                        count_next = count_reg + swrc_pkg::POS_W'(1);
                    end
                    lim_ok_next = (count_next >= swrc_pkg::POS_W'(len_eff));
                    lim_next    = count_next - swrc_pkg::POS_W'(len_eff);
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (max_exp_two || min_exp_two) begin
                    sctrl.expire = 1'b1;
                end else begin
                    sctrl.step = 1'b1;
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = hit;
                    m_tdata_next  = {20'(min_front), 20'(max_front),
                                     lim_reg + swrc_pkg::POS_W'(1)};
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            lim_ok_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            lim_ok_reg   <= lim_ok_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        lim_reg     <= lim_next;
        sample_reg  <= sample_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule
